### sv/sabs_pkg.sv
// ----------------------------------------------------------------------------
// sabs_pkg - shared types and constants of the stamp coverage sampler
// Item layout between front and back, register indexes, luma weights and
// bank sizing.
// ----------------------------------------------------------------------------
package sabs_pkg;

   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;

   localparam int SIZE_W      = 7;   // size registers and texel coordinates
   localparam int TEXEL_W     = 6;   // write coordinates
   localparam int BYTE_W      = 8;
   localparam int OFFSET_W    = 16;  // Q1.15 offsets
   localparam int FRAC_W      = 15;  // bilinear fractions, units of 2^-15
   localparam int COV_W       = 16;  // 8.8 coverage
   localparam int U_W         = 16;  // u in 0..32768
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // luma weights, 0.299 / 0.587 / 0.114 scaled by 2^16
   localparam logic [15:0] LUMA_R = 16'd19595;
   localparam logic [15:0] LUMA_G = 16'd38470;
   localparam logic [15:0] LUMA_B = 16'd7471;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // one word in flight between front and back
   typedef struct packed {
      op_type              op;
      logic                empty;   // sample against an empty image
      logic [SIZE_W-1:0]   col;     // write column or x0
      logic [SIZE_W-1:0]   row;     // write row or y0
      logic [FRAC_W-1:0]   tx;
      logic [FRAC_W-1:0]   ty;
      logic [COV_W-1:0]    wdata;   // texel coverage for writes
   } item_type;

   // address bits of one parity bank along one axis
   function automatic int half_bits(int max_dim);
      int lim;
      int half;
      lim  = (max_dim < 128) ? max_dim : 128;
      half = (lim + 1) / 2;
      return (half > 1) ? $clog2(half) : 1;
   endfunction

endpackage

### sv/stamp_alpha_bilinear_sampler_core.sv
// ----------------------------------------------------------------------------
// stamp_alpha_bilinear_sampler_core - brush stamp coverage sampler
// Keeps one 8.8 coverage word per stamp texel and answers bilinear,
// clamp-to-edge coverage queries at brush offsets.
// ----------------------------------------------------------------------------
//
//  channel   handshake             moves
//  -------   -------------------   --------------------------------------
//  req_*     start / busy          texel write or coverage sample word
//  rsp_*     rsp_strobe (1 cycle)  coverage word, one per sample
//  csr_*     csr_valid/csr_ready   image_width (0), image_height (1)
//
//  One word accepted per cycle while busy is low. A sample's coverage passes
//  through the queue, the bank read and stage 1 registers, the stage 2 and
//  stage 3 registers and the output register onto rsp_*; writes give no response.
//  The four parity banks of the store deliver the whole 2x2 neighborhood in
//  a single read.
//  Reset (synchronous) empties the queue and pipeline and zeroes both size
//  registers; store contents are undefined until written.
//  The receiver cannot stall; busy only rises if the queue fills, which the
//  back end's one-word-per-cycle drain keeps from happening.
//
module stamp_alpha_bilinear_sampler_core #(
   parameter int MAX_WIDTH  = sabs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sabs_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_kind,
   input  logic [sabs_pkg::TEXEL_W-1:0]          req_texel_x,
   input  logic [sabs_pkg::TEXEL_W-1:0]          req_texel_y,
   input  logic [sabs_pkg::BYTE_W-1:0]           req_red,
   input  logic [sabs_pkg::BYTE_W-1:0]           req_green,
   input  logic [sabs_pkg::BYTE_W-1:0]           req_blue,
   input  logic [sabs_pkg::BYTE_W-1:0]           req_alpha,
   input  logic signed [sabs_pkg::OFFSET_W-1:0]  req_offset_x,
   input  logic signed [sabs_pkg::OFFSET_W-1:0]  req_offset_y,
   // response
   output logic                                  rsp_strobe,
   output logic [sabs_pkg::COV_W-1:0]            rsp_coverage,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sabs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sabs_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import sabs_pkg::*;

   // ---- size registers ----
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] width_in;
   logic [SIZE_W-1:0] height_ff;
   logic [SIZE_W-1:0] height_in;
   logic [SIZE_W-1:0] img_w;
   logic [SIZE_W-1:0] img_h;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;  // unknown index: no effect
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // sizes past the store saturate to it
   assign img_w = (32'(width_ff) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : width_ff;
   assign img_h = (32'(height_ff) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : height_ff;

   // ---- front -> queue -> back ----
   logic     push;
   item_type push_item;
   logic     full;
   logic     pop;
   logic     head_valid;
   item_type head_item;

   assign busy = full;

   sabs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .start        (start),
      .full         (full),
      .img_w        (img_w),
      .img_h        (img_h),
      .req_kind     (req_kind),
      .req_texel_x  (req_texel_x),
      .req_texel_y  (req_texel_y),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .req_alpha    (req_alpha),
      .req_offset_x (req_offset_x),
      .req_offset_y (req_offset_y),
      .push         (push),
      .item         (push_item)
   );

   sabs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .full       (full)
   );

   sabs_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .img_w        (img_w),
      .img_h        (img_h),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_coverage (rsp_coverage)
   );

endmodule

### sv/sabs_front.sv
// ----------------------------------------------------------------------------
// sabs_front - request decode
// Turns a write into its texel coverage and a sample into texel position and
// fractions, then pushes the word to the queue.
// ----------------------------------------------------------------------------
module sabs_front #(
   parameter int MAX_WIDTH  = sabs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sabs_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                  start,
   input  logic                                  full,
   input  logic [sabs_pkg::SIZE_W-1:0]           img_w,
   input  logic [sabs_pkg::SIZE_W-1:0]           img_h,
   input  logic                                  req_kind,
   input  logic [sabs_pkg::TEXEL_W-1:0]          req_texel_x,
   input  logic [sabs_pkg::TEXEL_W-1:0]          req_texel_y,
   input  logic [sabs_pkg::BYTE_W-1:0]           req_red,
   input  logic [sabs_pkg::BYTE_W-1:0]           req_green,
   input  logic [sabs_pkg::BYTE_W-1:0]           req_blue,
   input  logic [sabs_pkg::BYTE_W-1:0]           req_alpha,
   input  logic signed [sabs_pkg::OFFSET_W-1:0]  req_offset_x,
   input  logic signed [sabs_pkg::OFFSET_W-1:0]  req_offset_y,
   output logic                                  push,
   output sabs_pkg::item_type                    item
);
   import sabs_pkg::*;

   // offset to u in 2^-15 units, clamped to 0..1
   function automatic logic [U_W-1:0] to_u(logic signed [OFFSET_W-1:0] d);
      logic signed [OFFSET_W+1:0] v;
      v = $signed({{2{d[OFFSET_W-1]}}, d}) + 18'sd16384;
      if (v < 0) begin
         return '0;
      end else if (v > 18'sd32768) begin
         return 16'h8000;
      end
      return v[U_W-1:0];
   endfunction

   logic [U_W-1:0]    ux;
   logic [U_W-1:0]    uy;
   logic [SIZE_W-1:0] wm1;
   logic [SIZE_W-1:0] hm1;
   logic [22:0]       px;
   logic [22:0]       py;
   logic [23:0]       luma;
   logic [COV_W-1:0]  cov;
   logic              in_range;

   assign ux  = to_u(req_offset_x);
   assign uy  = to_u(req_offset_y);
   assign wm1 = img_w - 7'd1;
   assign hm1 = img_h - 7'd1;
   assign px  = 23'(ux) * 23'(wm1);
   assign py  = 23'(uy) * 23'(hm1);

   assign luma = 24'(LUMA_R) * 24'(req_red) + 24'(LUMA_G) * 24'(req_green)
               + 24'(LUMA_B) * 24'(req_blue) + 24'd128;
   assign cov  = (req_alpha != '0) ? {req_alpha, 8'h00} : luma[23:8];

   assign in_range = (32'(req_texel_x) < MAX_WIDTH) && (32'(req_texel_y) < MAX_HEIGHT);

   always_comb begin
      item = '0;
      case (req_kind)
         1'b1: begin
            item.op    = OP_SAMPLE;
            item.empty = (img_w == '0) || (img_h == '0);
            item.col   = px[21:15];
            item.row   = py[21:15];
            item.tx    = px[FRAC_W-1:0];
            item.ty    = py[FRAC_W-1:0];
         end
         default: begin
            item.op    = OP_WRITE;
            item.col   = {1'b0, req_texel_x};
            item.row   = {1'b0, req_texel_y};
            item.wdata = cov;
         end
      endcase
   end

   // out-of-store writes are taken and dropped
   assign push = start && !full && (req_kind || in_range);

endmodule

### sv/sabs_queue.sv
// ----------------------------------------------------------------------------
// sabs_queue - word queue between front and back
// Small circular buffer; head is shown combinationally.
// ----------------------------------------------------------------------------
module sabs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sabs_pkg::item_type push_item,
   input  logic               pop,
   output logic               head_valid,
   output sabs_pkg::item_type head_item,
   output logic               full
);
   import sabs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_pop;

   assign head_valid = (count_ff != '0);
   assign head_item  = q_ff[rd_ptr_ff];
   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### sv/sabs_bank.sv
// ----------------------------------------------------------------------------
// sabs_bank - one parity bank of the coverage store
// One write and one registered read per cycle. Contents undefined until
// written.
// ----------------------------------------------------------------------------
module sabs_bank #(
   parameter int ADDR_W = 10
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [ADDR_W-1:0]                wr_addr,
   input  logic [sabs_pkg::COV_W-1:0]       wr_data,
   input  logic [ADDR_W-1:0]                rd_addr,
   output logic [sabs_pkg::COV_W-1:0]       rd_data
);
   import sabs_pkg::*;

   logic [COV_W-1:0] mem [2**ADDR_W];
   logic [COV_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sabs_back.sv
// ----------------------------------------------------------------------------
// sabs_back - store and bilinear blend
// Four parity banks give the 2x2 neighborhood in one read; then row blend,
// column blend product, and rounding to 8.8.
// ----------------------------------------------------------------------------
module sabs_back #(
   parameter int MAX_WIDTH  = sabs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sabs_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sabs_pkg::SIZE_W-1:0]   img_w,
   input  logic [sabs_pkg::SIZE_W-1:0]   img_h,
   input  logic                          head_valid,
   input  sabs_pkg::item_type            head_item,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic [sabs_pkg::COV_W-1:0]    rsp_coverage
);
   import sabs_pkg::*;

   localparam int XBW    = half_bits(MAX_WIDTH);
   localparam int YBW    = half_bits(MAX_HEIGHT);
   localparam int ADDR_W = XBW + YBW;

   // ---- stage 0: bank addressing ----
   logic              is_write;
   logic              is_sample;
   logic [SIZE_W-1:0] col_p1;
   logic [SIZE_W-1:0] row_p1;
   logic              xclamp;
   logic              yclamp;
   logic [COV_W-1:0]  rd [4];

   assign pop       = head_valid;
   assign is_write  = head_valid && (head_item.op == OP_WRITE);
   assign is_sample = head_valid && (head_item.op == OP_SAMPLE);
   assign col_p1    = head_item.col + 7'd1;
   assign row_p1    = head_item.row + 7'd1;
   assign xclamp    = !((8'(head_item.col) + 8'd1) < 8'(img_w));
   assign yclamp    = !((8'(head_item.row) + 8'd1) < 8'(img_h));

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [SIZE_W-1:0] c_sel;
      logic [SIZE_W-1:0] r_sel;
      logic [ADDR_W-1:0] raddr;
      logic [ADDR_W-1:0] waddr;
      logic              we;

      // bank b holds column parity b[0], row parity b[1]
      assign c_sel = (head_item.col[0] == b[0]) ? head_item.col : col_p1;
      assign r_sel = (head_item.row[0] == b[1]) ? head_item.row : row_p1;
      assign raddr = {r_sel[YBW:1], c_sel[XBW:1]};
      assign waddr = {head_item.row[YBW:1], head_item.col[XBW:1]};
      assign we    = is_write && (head_item.col[0] == b[0]) && (head_item.row[0] == b[1]);

      sabs_bank #(.ADDR_W(ADDR_W)) u_bank (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (waddr),
         .wr_data (head_item.wdata),
         .rd_addr (raddr),
         .rd_data (rd[b])
      );
   end

   // ---- stage 1: pick neighbors, blend along x ----
   logic              s1_valid_ff;
   logic              s1_empty_ff;
   logic              s1_xp_ff;
   logic              s1_yp_ff;
   logic              s1_xclamp_ff;
   logic              s1_yclamp_ff;
   logic [FRAC_W-1:0] s1_tx_ff;
   logic [FRAC_W-1:0] s1_ty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= is_sample;
      end
   end

   always_ff @(posedge clock) begin
      s1_empty_ff  <= head_item.empty;
      s1_xp_ff     <= head_item.col[0];
      s1_yp_ff     <= head_item.row[0];
      s1_xclamp_ff <= xclamp;
      s1_yclamp_ff <= yclamp;
      s1_tx_ff     <= head_item.tx;
      s1_ty_ff     <= head_item.ty;
   end

   logic [COV_W-1:0]  a0;
   logic [COV_W-1:0]  b0;
   logic [COV_W-1:0]  a1;
   logic [COV_W-1:0]  b1;
   logic signed [16:0] d0;
   logic signed [16:0] d1;
   logic signed [32:0] top_s;
   logic signed [32:0] bot_s;

   always_comb begin
      a0 = rd[{s1_yp_ff, s1_xp_ff}];
      b0 = s1_xclamp_ff ? a0 : rd[{s1_yp_ff, !s1_xp_ff}];
      a1 = s1_yclamp_ff ? a0 : rd[{!s1_yp_ff, s1_xp_ff}];
      b1 = s1_yclamp_ff ? b0 : (s1_xclamp_ff ? a1 : rd[{!s1_yp_ff, !s1_xp_ff}]);
      d0 = $signed({1'b0, b0}) - $signed({1'b0, a0});
      d1 = $signed({1'b0, b1}) - $signed({1'b0, a1});
      // a*(1-t) + b*t == a + (b-a)*t
      top_s = $signed({2'b00, a0, 15'b0}) + d0 * $signed({1'b0, s1_tx_ff});
      bot_s = $signed({2'b00, a1, 15'b0}) + d1 * $signed({1'b0, s1_tx_ff});
   end

   // ---- stage 2: blend along y, product ----
   logic              s2_valid_ff;
   logic              s2_empty_ff;
   logic [30:0]       s2_top_ff;
   logic [30:0]       s2_bot_ff;
   logic [FRAC_W-1:0] s2_ty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_empty_ff <= s1_empty_ff;
      s2_top_ff   <= top_s[30:0];
      s2_bot_ff   <= bot_s[30:0];
      s2_ty_ff    <= s1_ty_ff;
   end

   logic signed [31:0] dy;
   logic signed [47:0] prod_in;

   assign dy      = $signed({1'b0, s2_bot_ff}) - $signed({1'b0, s2_top_ff});
   assign prod_in = dy * $signed({1'b0, s2_ty_ff});

   // ---- stage 3: sum, round half up, output ----
   logic              s3_valid_ff;
   logic              s3_empty_ff;
   logic [30:0]       s3_top_ff;
   logic signed [47:0] s3_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_empty_ff <= s2_empty_ff;
      s3_top_ff   <= s2_top_ff;
      s3_prod_ff  <= prod_in;
   end

   logic signed [47:0] sum;
   logic              out_strobe_ff;
   logic [COV_W-1:0]  out_cov_ff;
   logic [COV_W-1:0]  out_cov_in;

   assign sum        = $signed({2'b00, s3_top_ff, 15'b0}) + s3_prod_ff + 48'sh2000_0000;
   assign out_cov_in = s3_empty_ff ? '0 : sum[45:30];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_cov_ff <= out_cov_in;
   end

   assign rsp_strobe   = out_strobe_ff;
   assign rsp_coverage = out_cov_ff;

endmodule
